FILE: rtl/kbvmc_pkg.sv
// Shared types and constants for the knapsack best-value / min-cost block.
// Used by kbvmc_alu, kbvmc_seq and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kbvmc_pkg;

   // Fixed field widths of the item and result streams.
   localparam int ITEM_VALUE_W = 8;
   localparam int COST_W       = 9;
   localparam int VALUE_W      = 15;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;

   // Table sums saturate here.
   localparam logic [VALUE_W-1:0] VALUE_CEIL = 15'd32767;

   // Default sizing handed to the top level.
   localparam int CAPACITY_SLOTS_DEF = 512;
   localparam int MAX_ITEMS_DEF      = 128;

   // Result of the shared add/compare unit.
   typedef struct packed {
      logic [VALUE_W-1:0] upd;  // max(entry c, sat(entry c-cost + value))
      logic               hit;  // entry c equals the reference value
   } alu_out_type;

   // Control from the sequencer to the table and the result register.
   typedef struct packed {
      logic wr_en;    // write the table this cycle
      logic wr_zero;  // write zero (clearing pass) instead of the unit result
      logic emit;     // load the result register this cycle
   } seq_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/kbvmc_table.sv
// Value table memory: one write port, two read ports with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module kbvmc_table #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int W     = 15
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_data,
   input  wire logic [AW-1:0] rd_a_addr,
   input  wire logic [AW-1:0] rd_b_addr,
   output logic      [W-1:0]  rd_a_data,
   output logic      [W-1:0]  rd_b_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_a_ff;
   logic [W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/kbvmc_alu.sv
// Shared arithmetic unit: saturating add, max select and equality compare.
// Depends on kbvmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbvmc_alu (
   input  wire logic [kbvmc_pkg::VALUE_W-1:0]      entry_c,
   input  wire logic [kbvmc_pkg::VALUE_W-1:0]      entry_back,
   input  wire logic [kbvmc_pkg::ITEM_VALUE_W-1:0] addend,
   input  wire logic [kbvmc_pkg::VALUE_W-1:0]      ref_value,
   output kbvmc_pkg::alu_out_type                  result
);

   logic [kbvmc_pkg::VALUE_W:0]   sum;
   logic [kbvmc_pkg::VALUE_W-1:0] cand;

   always_comb begin
      sum  = {1'b0, entry_back} + (kbvmc_pkg::VALUE_W + 1)'(addend);
      cand = (sum > (kbvmc_pkg::VALUE_W + 1)'(kbvmc_pkg::VALUE_CEIL)) ?
             kbvmc_pkg::VALUE_CEIL : sum[kbvmc_pkg::VALUE_W-1:0];
      result.upd = (cand > entry_c) ? cand : entry_c;
      result.hit = (entry_c == ref_value);
   end

endmodule

`default_nettype wire

FILE: rtl/kbvmc_seq.sv
// Sequencer: accepts items, walks the table for fold, peek, scan and clear.
// Depends on kbvmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbvmc_seq #(
   parameter int CAPACITY_SLOTS = kbvmc_pkg::CAPACITY_SLOTS_DEF,
   parameter int MAX_ITEMS      = kbvmc_pkg::MAX_ITEMS_DEF,
   parameter int AW             = $clog2(CAPACITY_SLOTS)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic [kbvmc_pkg::ITEM_VALUE_W-1:0]  req_value,
   input  wire logic [kbvmc_pkg::COST_W-1:0]        req_cost,
   input  wire logic                                req_last,
   output logic                                     req_ready,
   input  wire logic [AW-1:0]                       limit,
   input  wire logic                                slot_free,
   input  wire logic [kbvmc_pkg::VALUE_W-1:0]       rd_a_data,
   input  wire kbvmc_pkg::alu_out_type              alu_res,
   output logic [AW-1:0]                            rd_a_addr,
   output logic [AW-1:0]                            rd_b_addr,
   output logic [AW-1:0]                            wr_addr,
   output kbvmc_pkg::seq_ctl_type                   ctl,
   output logic [kbvmc_pkg::ITEM_VALUE_W-1:0]       addend,
   output logic [kbvmc_pkg::VALUE_W-1:0]            best,
   output logic [AW-1:0]                            least
);

   localparam int IW = $clog2(MAX_ITEMS + 1);
   localparam logic [AW-1:0] TOP_ADDR = AW'(CAPACITY_SLOTS - 1);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_FOLD  = 8'b0000_0100,
      ST_DRAIN = 8'b0000_1000,
      ST_PEEK  = 8'b0001_0000,
      ST_LOAD  = 8'b0010_0000,
      ST_SCAN  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type                           state_ff, state_in;
   logic [AW-1:0]                       idx_ff, idx_in;
   logic [AW-1:0]                       cost_ff, cost_in;
   logic [kbvmc_pkg::ITEM_VALUE_W-1:0]  value_ff, value_in;
   logic                                last_ff, last_in;
   logic [IW-1:0]                       seen_ff, seen_in;
   logic                                wb_valid_ff, wb_valid_in;
   logic [AW-1:0]                       wb_addr_ff, wb_addr_in;
   logic [kbvmc_pkg::VALUE_W-1:0]       best_ff, best_in;
   logic [AW-1:0]                       least_ff, least_in;
   logic                                take;
   logic                                can_fold;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cost_in     = cost_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      seen_in     = seen_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = wb_addr_ff;
      best_in     = best_ff;
      least_in    = least_ff;
      rd_a_addr   = idx_ff;
      rd_b_addr   = idx_ff - cost_ff;
      wr_addr     = wb_addr_ff;
      ctl.wr_en   = wb_valid_ff;
      ctl.wr_zero = 1'b0;
      ctl.emit    = 1'b0;
      req_ready   = 1'b0;
      take        = 1'b0;
      can_fold    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_zero = 1'b1;
            wr_addr     = idx_ff;
            if (idx_ff == TOP_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            take      = req_valid;
            can_fold  = (seen_ff < IW'(MAX_ITEMS)) &&
                        (32'(req_cost) <= 32'(CAPACITY_SLOTS - 1));
            if (take) begin
               value_in = req_value;
               cost_in  = AW'(req_cost);
               last_in  = req_last;
               if (seen_ff < IW'(MAX_ITEMS)) begin
                  seen_in = seen_ff + IW'(1);
               end
               if (can_fold) begin
                  idx_in   = TOP_ADDR;
                  state_in = ST_FOLD;
               end else if (req_last) begin
                  state_in = ST_PEEK;
               end
            end
         end
         ST_FOLD: begin
            // Reads at idx and idx - cost now, write back at idx next cycle.
            wb_valid_in = 1'b1;
            wb_addr_in  = idx_ff;
            if (idx_ff == cost_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_PEEK : ST_IDLE;
         end
         ST_PEEK: begin
            rd_a_addr = limit;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            best_in   = rd_a_data;
            rd_a_addr = '0;
            idx_in    = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // Read data belongs to idx; the entry at the limit always matches.
            if (alu_res.hit) begin
               least_in = idx_ff;
               state_in = ST_EMIT;
            end else begin
               idx_in    = idx_ff + AW'(1);
               rd_a_addr = idx_ff + AW'(1);
            end
         end
         ST_EMIT: begin
            ctl.emit = slot_free;
            if (slot_free) begin
               seen_in  = '0;
               idx_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         idx_ff      <= '0;
         seen_ff     <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         seen_ff     <= seen_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff    <= cost_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      wb_addr_ff <= wb_addr_in;
      best_ff    <= best_in;
      least_ff   <= least_in;
   end

   assign addend = value_ff;
   assign best   = best_ff;
   assign least  = least_ff;

endmodule

`default_nettype wire

FILE: rtl/knapsack_best_value_min_cost.sv
// Top level of the 0/1 knapsack best-value / min-cost block.
// Depends on kbvmc_pkg, kbvmc_table, kbvmc_alu and kbvmc_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each req item (value, cost) is folded into a table whose entry c holds the
// best total value of a subset of the set's items costing at most c. For one
// item the sequencer walks the table from the top entry down to the cost, one
// read-modify-write per cycle through a single saturating add-and-max unit on
// the two-read, one-write table memory, after a step to accept the item and
// before a drain step that retires the last write. Items past MAX_ITEMS or
// costing more than CAPACITY_SLOTS - 1 are accepted and change nothing. An
// item with tlast set is then followed by a read of the entry at the budget,
// clamped to the table, a scan upward for the first equal entry, a hand-off
// of the result to the rsp output register, and a clearing pass over every
// table entry. The same clearing pass runs after reset; req_tready stays low
// throughout. The user must write the budget through csr_wr_en/csr_wr_data
// only while the block is idle; the block itself does not enforce this.
module knapsack_best_value_min_cost #(
   parameter int CAPACITY_SLOTS = kbvmc_pkg::CAPACITY_SLOTS_DEF,
   parameter int MAX_ITEMS      = kbvmc_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Item stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] item_value, [16:8] item_cost, [23:17] zero
   input  wire logic [kbvmc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                                req_tlast,   // last_item
   // Result stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [8:0] min_cost, [23:9] best_value
   output logic [kbvmc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // Budget register.
   input  wire logic                                csr_wr_en,
   input  wire logic [kbvmc_pkg::COST_W-1:0]        csr_wr_data
);

   localparam int AW = $clog2(CAPACITY_SLOTS);

   logic [kbvmc_pkg::COST_W-1:0]       budget_ff;
   logic [AW-1:0]                      limit;
   logic                               rsp_valid_ff;
   logic [kbvmc_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic                               slot_free;

   logic [AW-1:0]                      rd_a_addr, rd_b_addr, wr_addr;
   logic [kbvmc_pkg::VALUE_W-1:0]      rd_a_data, rd_b_data, wr_data;
   logic [kbvmc_pkg::ITEM_VALUE_W-1:0] addend;
   logic [kbvmc_pkg::VALUE_W-1:0]      best;
   logic [AW-1:0]                      least;
   kbvmc_pkg::seq_ctl_type             ctl;
   kbvmc_pkg::alu_out_type             alu_res;

   // Budget register, clamped to the top table entry for use.
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
      end else if (csr_wr_en) begin
         budget_ff <= csr_wr_data;
      end
   end

   assign limit = (32'(budget_ff) > 32'(CAPACITY_SLOTS - 1)) ?
                  AW'(CAPACITY_SLOTS - 1) : AW'(budget_ff);

   // The result register frees the sequencer once the result is loaded, so
   // the clearing pass runs while the result waits downstream.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_data_ff <= {best, kbvmc_pkg::COST_W'(least)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Table writes carry either the fold result or zero during clearing.
   assign wr_data = ctl.wr_zero ? '0 : alu_res.upd;

   kbvmc_table #(
      .DEPTH (CAPACITY_SLOTS),
      .AW    (AW),
      .W     (kbvmc_pkg::VALUE_W)
   ) u_table (
      .clock     (clock),
      .wr_en     (ctl.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   kbvmc_alu u_alu (
      .entry_c    (rd_a_data),
      .entry_back (rd_b_data),
      .addend     (addend),
      .ref_value  (best),
      .result     (alu_res)
   );

   kbvmc_seq #(
      .CAPACITY_SLOTS (CAPACITY_SLOTS),
      .MAX_ITEMS      (MAX_ITEMS),
      .AW             (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_value (req_tdata[7:0]),
      .req_cost  (req_tdata[16:8]),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .limit     (limit),
      .slot_free (slot_free),
      .rd_a_data (rd_a_data),
      .alu_res   (alu_res),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr_addr   (wr_addr),
      .ctl       (ctl),
      .addend    (addend),
      .best      (best),
      .least     (least)
   );

   // A result is only loaded when the output register can take it.
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> slot_free)
      else $error("result loaded over an unaccepted result");

   // The least cost never exceeds the clamped budget.
   a_least_in_budget: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (least <= limit))
      else $error("min_cost beyond budget");

   // After a result the clearing pass runs before any new item is taken.
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> !req_tready)
      else $error("item accepted before table cleared");

   // Zeroing writes only happen while items are refused.
   a_zero_when_busy: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && ctl.wr_zero) |-> !req_tready)
      else $error("table cleared while accepting items");

endmodule

`default_nettype wire
